// ===== sv/tsces_pkg.sv =====
package tsces_pkg;

  // channel count, tick period of the counter and result limit per item
  localparam int unsigned CHANNELS       = 4;
  localparam int unsigned TICK_PERIOD_US = 1;
  localparam int unsigned MAX_RESULTS    = 4;

  localparam int unsigned CH_W     = 2;
  localparam int unsigned CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CNT_W    = $clog2(MAX_RESULTS + 1);
  localparam int unsigned RES_IDX_W = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

  typedef enum logic [1:0] {
    ST_EXPIRY   = 2'd0,
    ST_FORCED   = 2'd1,
    ST_REJECTED = 2'd2
  } status_e;

  typedef enum logic {
    FUNC_SET  = 1'b0,
    FUNC_TICK = 1'b1
  } func_e;

  typedef enum logic {
    REG_MIN_INTERVAL = 1'b0,
    REG_MAX_INTERVAL = 1'b1
  } reg_e;

  typedef struct packed {
    func_e              func;
    logic [CH_W-1:0]    channel;
    logic [TIME_W-1:0]  delay1_us;
    logic [TIME_W-1:0]  delay2_us;
    logic               level1;
    logic               level2;
    logic               second_enabled;
    logic               finish_on_rearm;
  } item_t;

  typedef struct packed {
    logic [CH_W-1:0] channel;
    logic            level;
    status_e         status;
  } result_t;

  typedef struct packed {
    result_t [MAX_RESULTS-1:0] res;
    logic    [CNT_W-1:0]       count;
  } batch_t;

  typedef struct packed {
    logic [TIME_W-1:0] min_us;
    logic [TIME_W-1:0] max_us;
  } cfg_t;

  // delay in microseconds to counter ticks
  function automatic logic [TIME_W-1:0] us_to_ticks(input logic [TIME_W-1:0] us);
    return us / TICK_PERIOD_US;
  endfunction

endpackage

// ===== sv/tsces_core.sv =====
module tsces_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  tsces_pkg::item_t item_i,
  input  tsces_pkg::cfg_t  cfg_i,
  output tsces_pkg::batch_t batch_o
);
  import tsces_pkg::*;

  logic [TIME_W-1:0]   tick_q, tick_d;
  logic [CHANNELS-1:0] armed_q, armed_d;
  logic [CHANNELS-1:0] first_q, first_d;
  logic [CHANNELS-1:0] a1_q, a1_d;
  logic [CHANNELS-1:0] a2_q, a2_d;
  logic [CHANNELS-1:0] sec_en_q, sec_en_d;
  logic [CHANNELS-1:0] fin_q, fin_d;
  logic [TIME_W-1:0]   cmp_q [CHANNELS];
  logic [TIME_W-1:0]   cmp_d [CHANNELS];
  logic [TIME_W-1:0]   second_q [CHANNELS];
  logic [TIME_W-1:0]   second_d [CHANNELS];

  logic [CNT_W-1:0]    pos;
  logic [CH_IDX_W-1:0] ch_idx;
  logic                in_range;
  logic                reject;
  logic [TIME_W-1:0]   i1_c, i2_c;

  assign ch_idx   = CH_IDX_W'(item_i.channel);
  assign in_range = (int'(item_i.channel) < int'(CHANNELS));
  assign reject   = (item_i.delay1_us > cfg_i.max_us) ||
                    (item_i.second_enabled && (item_i.delay2_us > cfg_i.max_us));
  assign i1_c     = (item_i.delay1_us < cfg_i.min_us) ? cfg_i.min_us
                                                      : item_i.delay1_us;
  assign i2_c     = (item_i.second_enabled && (item_i.delay2_us < cfg_i.min_us))
                    ? cfg_i.min_us : item_i.delay2_us;

  always_comb begin
    batch_o  = '0;
    pos      = '0;
    tick_d   = tick_q;
    armed_d  = armed_q;
    first_d  = first_q;
    a1_d     = a1_q;
    a2_d     = a2_q;
    sec_en_d = sec_en_q;
    fin_d    = fin_q;
    cmp_d    = cmp_q;
    second_d = second_q;
    if (item_i.func == FUNC_TICK) begin
      tick_d = tick_q + TIME_W'(1);
      // every channel is checked once, ascending, against the advanced count
      for (int c = 0; c < int'(CHANNELS); c++) begin
        if (armed_q[c] && (cmp_q[c] == tick_d)) begin
          batch_o.res[pos[RES_IDX_W-1:0]].channel = CH_W'(c);
          batch_o.res[pos[RES_IDX_W-1:0]].status  = ST_EXPIRY;
          if (!first_q[c]) begin
            batch_o.res[pos[RES_IDX_W-1:0]].level = a1_q[c];
            if (sec_en_q[c]) begin
              first_d[c] = 1'b1;
              cmp_d[c]   = tick_d + us_to_ticks(second_q[c]);
            end else begin
              armed_d[c] = 1'b0;
              first_d[c] = 1'b0;
            end
          end else begin
            batch_o.res[pos[RES_IDX_W-1:0]].level = a2_q[c];
            armed_d[c] = 1'b0;
            first_d[c] = 1'b0;
          end
          pos = pos + CNT_W'(1);
        end
      end
      batch_o.count = pos;
    end else if (in_range) begin
      batch_o.res[0].channel = item_i.channel;
      if (reject) begin
        batch_o.res[0].level  = 1'b0;
        batch_o.res[0].status = ST_REJECTED;
        batch_o.count         = CNT_W'(1);
      end else begin
        if (armed_q[ch_idx] && fin_q[ch_idx]) begin
          // pending action fires before the channel is re-armed
          batch_o.res[0].level  = (sec_en_q[ch_idx] && first_q[ch_idx]) ? a2_q[ch_idx]
                                                                        : a1_q[ch_idx];
          batch_o.res[0].status = ST_FORCED;
          batch_o.count         = CNT_W'(1);
        end
        armed_d[ch_idx]  = 1'b1;
        first_d[ch_idx]  = 1'b0;
        a1_d[ch_idx]     = item_i.level1;
        a2_d[ch_idx]     = item_i.level2;
        sec_en_d[ch_idx] = item_i.second_enabled;
        fin_d[ch_idx]    = item_i.finish_on_rearm;
        second_d[ch_idx] = i2_c;
        cmp_d[ch_idx]    = tick_q + us_to_ticks(i1_c);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      armed_q <= '0;
      first_q <= '0;
    end else if (fire_i) begin
      tick_q  <= tick_d;
      armed_q <= armed_d;
      first_q <= first_d;
    end
  end

  // per-channel payload, only looked at while the channel is armed
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      a1_q     <= a1_d;
      a2_q     <= a2_d;
      sec_en_q <= sec_en_d;
      fin_q    <= fin_d;
      cmp_q    <= cmp_d;
      second_q <= second_d;
    end
  end

endmodule

// ===== sv/two_stage_channel_event_scheduler_top.sv =====
// Two-stage event scheduler for four actor channels (ignition 1, ignition 2, fuel 1,
// fuel 2) on a 32-bit tick counter. A set beat (tuser 0) arms one channel
// with one or two delays and the actor level of each stage; a tick beat (tuser 1)
// advances the counter and fires every channel whose compare value it reaches, lowest
// channel first. An item is taken into an input register and is evaluated
// combinationally against the channel state, its results going into a result register
// that drains one beat per cycle while m_axis_tready is high. A set gives at most one
// result, a tick up to four, and the next item is evaluated in the cycle the last beat
// of the previous one is taken. Result beats of one item end with tlast.
module two_stage_channel_event_scheduler_top (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // channel[1:0], delay1_us[33:2], delay2_us[65:34], level1[66],
  // level2[67], second_enabled[68], finish_on_rearm[69], zero pad [71:70]
  input  logic [71:0] s_axis_tdata,
  // func[0]
  input  logic        s_axis_tuser,

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_channel[1:0], actor_level[2], zero pad [7:3]
  output logic [7:0]  m_axis_tdata,
  // status[1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_addr_i,
  input  logic [31:0] cfg_data_i
);
  import tsces_pkg::*;

  // configuration registers
  cfg_t cfg_q;

  // input register
  item_t in_q;
  logic  in_valid_q, in_valid_d;

  // result register, shifted down as beats leave
  result_t [MAX_RESULTS-1:0] res_q;
  logic    [CNT_W-1:0]       cnt_q;

  batch_t batch;
  logic   batch_free;
  logic   proc;
  logic   in_take;
  logic   out_take;

  assign out_take   = m_axis_tvalid && m_axis_tready;
  // result register is empty now or after the beat taken this cycle
  assign batch_free = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && m_axis_tready);
  assign proc       = in_valid_q && batch_free;
  assign s_axis_tready = !in_valid_q || proc;
  assign in_take    = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (proc) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.func            <= func_e'(s_axis_tuser);
      in_q.channel         <= s_axis_tdata[1:0];
      in_q.delay1_us       <= s_axis_tdata[33:2];
      in_q.delay2_us       <= s_axis_tdata[65:34];
      in_q.level1          <= s_axis_tdata[66];
      in_q.level2          <= s_axis_tdata[67];
      in_q.second_enabled  <= s_axis_tdata[68];
      in_q.finish_on_rearm <= s_axis_tdata[69];
    end
  end

  // channel state and per-item evaluation
  tsces_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (proc),
    .item_i (in_q),
    .cfg_i  (cfg_q),
    .batch_o(batch)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (proc) begin
      cnt_q <= batch.count;
    end else if (out_take) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      res_q <= batch.res;
    end else if (out_take) begin
      for (int k = 0; k < int'(MAX_RESULTS) - 1; k++) begin
        res_q[k] <= res_q[k+1];
      end
    end
  end

  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tlast  = (cnt_q == CNT_W'(1));
  assign m_axis_tdata  = {5'b0, res_q[0].level, res_q[0].channel};
  assign m_axis_tuser  = res_q[0].status;

  // config writes are always accepted; the one address bit selects the min or max register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_us <= TIME_W'(10);
      cfg_q.max_us <= TIME_W'(2000000);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (reg_e'(cfg_addr_i))
        REG_MIN_INTERVAL: cfg_q.min_us <= cfg_data_i;
        REG_MAX_INTERVAL: cfg_q.max_us <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/tsces_checker.sv =====
module tsces_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import tsces_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  // a forced or rejected result is the only result of its set item
  a_set_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_FORCED || m_axis_tuser == ST_REJECTED)
      |-> m_axis_tlast)
    else $error("set result not last of its item");

  // rejection never drives the actor
  a_reject_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_REJECTED) |-> !m_axis_tdata[2])
    else $error("rejected set with actor level high");

  // no status code beyond the defined ones
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == ST_EXPIRY || m_axis_tuser == ST_FORCED ||
                       m_axis_tuser == ST_REJECTED))
    else $error("undefined result status");

  // padding of the result beat stays zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:3] == 5'b0))
    else $error("result padding not zero");

endmodule

bind two_stage_channel_event_scheduler_top tsces_checker u_tsces_checker (.*);
